@@ src/mfbfs_pkg.sv @@
// Package: shared constants and types for the max-flow core.
`timescale 1ns / 1ps
package mfbfs_pkg;
    localparam int MAX_NODES_DEF = 16;
    localparam int NODE_W        = 4;
    localparam int CFG_W         = 5;
    localparam int CAP_W         = 2;
    localparam int FLOW_W        = 4;
    localparam logic [CAP_W-1:0]  CAP_MAX  = 2'd3;
    localparam logic [FLOW_W-1:0] FLOW_MAX = 4'd15;
    localparam logic [CFG_W-1:0]  NODE_COUNT_RST = 5'd16;
    localparam logic [1:0]        ADDR_NODE_COUNT = 2'd0;
    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_RUN = 1'b1;
endpackage

@@ src/max_flow_bfs_augment_core.sv @@
// Add edge: sets capacity 1 for an edge inside the node range, no result. Run: search
// rounds, each followed by an augment along the path found; out_valid rises after
// the last search gives up, or straight from S_IDLE via S_DONE when N < 2.
// Throughput: one transaction at a time; in_stall high while busy or a result waits.
// The capacity memory, one read with a registered result and one write a cycle,
// sets the pace of search, bottleneck scan and update.
// Reset: asynchronous active low; capacities read as zero, node_count 16.
`timescale 1ns / 1ps
module max_flow_bfs_augment_core
    import mfbfs_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              req_type,
    input  logic [NODE_W-1:0] from_node,
    input  logic [NODE_W-1:0] to_node,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [FLOW_W-1:0] max_flow
);
    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = IW + 1;
    localparam int AW = 2 * IW;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_BINIT = 9'b000000010,
        S_POP   = 9'b000000100,
        S_SCAN  = 9'b000001000,
        S_CHK   = 9'b000010000,
        S_BRD   = 9'b000100000,
        S_BCHK  = 9'b001000000,
        S_UPD   = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [CFG_W-1:0] node_count_reg;
    logic [IW-1:0] parent_mem [MAX_NODES];
    logic [IW-1:0] queue_mem [MAX_NODES];
    logic [MAX_NODES-1:0] seen_reg;
    logic [CW-1:0] head_reg, tail_reg, steps_reg;
    logic [IW-1:0] u_reg, v_reg, sink_reg;
    logic [CAP_W-1:0] bott_reg;
    logic [FLOW_W-1:0] total_reg;
    logic phase_reg;
    logic out_valid_reg;

    logic mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [CAP_W-1:0] mem_wdata, mem_rdata;
    logic [CW-1:0] n_eff;
    logic [IW-1:0] par_v;
    logic in_acc;
    logic last_v;

    mfbfs_capmem #(.AW(AW)) u_cap (
        .clk(clk), .rst_n(rst_n), .we(mem_we), .waddr(mem_waddr),
        .wdata(mem_wdata), .raddr(mem_raddr), .rdata(mem_rdata)
    );

    // Configuration port: always ready, one register.
    assign pready = 1'b1;
    assign prdata = {{(32-CFG_W){1'b0}}, node_count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RST;
        end
        else if (psel && penable && pwrite && paddr == ADDR_NODE_COUNT)
        begin
            node_count_reg <= pwdata[CFG_W-1:0];
        end
    end

    // Clamp node count to the array size.
    always_comb
    begin
        if ({{(32-CFG_W){1'b0}}, node_count_reg} > 32'(MAX_NODES))
        begin
            n_eff = CW'(MAX_NODES);
        end
        else
        begin
            n_eff = CW'(node_count_reg);
        end
    end

    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign max_flow  = total_reg;
    assign par_v     = parent_mem[v_reg];

    assign in_acc = in_valid && !in_stall;

    // Memory port use per state. Update of one path edge: the forward read is
    // issued in S_BRD, the forward write and the reverse read in S_BCHK, the
    // saturated reverse write in S_UPD.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = {u_reg, v_reg};
        if (in_acc && req_type == REQ_ADD)
        begin
            mem_we    = (32'(from_node) < 32'(n_eff)) && (32'(to_node) < 32'(n_eff));
            mem_waddr = {IW'(from_node), IW'(to_node)};
            mem_wdata = CAP_W'(1);
        end
        else if (state_reg == S_BRD)
        begin
            mem_raddr = {par_v, v_reg};
        end
        else if (state_reg == S_BCHK && phase_reg)
        begin
            mem_raddr = {v_reg, par_v};
            mem_we    = 1'b1;
            mem_waddr = {par_v, v_reg};
            mem_wdata = mem_rdata - bott_reg;
        end
        else if (state_reg == S_UPD)
        begin
            mem_we    = 1'b1;
            mem_waddr = {v_reg, par_v};
            mem_wdata = ({1'b0, mem_rdata} + {1'b0, bott_reg} > {1'b0, CAP_MAX})
                        ? CAP_MAX : mem_rdata + bott_reg;
        end
    end

    assign last_v = ({1'b0, v_reg} == n_eff - CW'(1));

    // Phase 0 walks the path for the bottleneck, phase 1 walks it again to update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            seen_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            total_reg     <= '0;
            phase_reg     <= 1'b0;
            steps_reg     <= '0;
            u_reg         <= '0;
            v_reg         <= '0;
            sink_reg      <= '0;
            bott_reg      <= '0;
            parent_mem    <= '{default: '0};
            queue_mem     <= '{default: '0};
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && req_type == REQ_RUN)
                    begin
                        total_reg <= '0;
                        sink_reg  <= IW'(n_eff - CW'(1));
                        if (n_eff < CW'(2))
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_BINIT;
                        end
                    end
                end
                S_BINIT:
                begin
                    seen_reg     <= {{(MAX_NODES-1){1'b0}}, 1'b1};
                    queue_mem[0] <= '0;
                    parent_mem[0] <= '0;
                    head_reg     <= '0;
                    tail_reg     <= CW'(1);
                    state_reg    <= S_POP;
                end
                S_POP:
                begin
                    if (head_reg < tail_reg && head_reg < CW'(MAX_NODES))
                    begin
                        u_reg     <= queue_mem[head_reg[IW-1:0]];
                        head_reg  <= head_reg + CW'(1);
                        v_reg     <= '0;
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_SCAN:
                begin
                    // read issued at {u,v}; data next cycle
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (!seen_reg[v_reg] && mem_rdata != '0)
                    begin
                        if (tail_reg < CW'(MAX_NODES))
                        begin
                            queue_mem[tail_reg[IW-1:0]] <= v_reg;
                            tail_reg <= tail_reg + CW'(1);
                        end
                        parent_mem[v_reg] <= u_reg;
                        seen_reg[v_reg]   <= 1'b1;
                        if (v_reg == sink_reg)
                        begin
                            bott_reg  <= CAP_MAX;
                            steps_reg <= '0;
                            phase_reg <= 1'b0;
                            state_reg <= S_BRD;
                        end
                    end
                    if (!(!seen_reg[v_reg] && mem_rdata != '0 && v_reg == sink_reg))
                    begin
                        if (last_v)
                        begin
                            state_reg <= S_POP;
                        end
                        else
                        begin
                            v_reg     <= v_reg + IW'(1);
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_BRD:
                begin
                    // forward read issued at {parent,v}
                    if (v_reg == '0 || steps_reg >= n_eff)
                    begin
                        if (!phase_reg)
                        begin
                            phase_reg <= 1'b1;
                            v_reg     <= sink_reg;
                            steps_reg <= '0;
                            state_reg <= S_BRD;
                        end
                        else
                        begin
                            total_reg <= ({1'b0, total_reg} + {3'b0, bott_reg} > {1'b0, FLOW_MAX})
                                         ? FLOW_MAX : total_reg + FLOW_W'(bott_reg);
                            state_reg <= S_BINIT;
                        end
                    end
                    else
                    begin
                        state_reg <= S_BCHK;
                    end
                end
                S_BCHK:
                begin
                    if (!phase_reg)
                    begin
                        if (mem_rdata < bott_reg)
                        begin
                            bott_reg <= mem_rdata;
                        end
                        v_reg     <= par_v;
                        steps_reg <= steps_reg + CW'(1);
                        state_reg <= S_BRD;
                    end
                    else
                    begin
                        // forward lowered now; reverse read in flight
                        state_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    // reverse raised now; advance toward the source
                    v_reg     <= par_v;
                    steps_reg <= steps_reg + CW'(1);
                    state_reg <= S_BRD;
                end
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(max_flow));
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall);
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg));
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> (state_reg == S_IDLE) && !out_valid_reg);
endmodule

@@ src/mfbfs_capmem.sv @@
// Residual capacity memory with valid bits per entry.
`timescale 1ns / 1ps
module mfbfs_capmem
    import mfbfs_pkg::*;
#(
    parameter int AW = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [CAP_W-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [CAP_W-1:0] rdata
);
    localparam int DEPTH = 1 << AW;
    logic [CAP_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [CAP_W-1:0] rd_reg;
    logic             rv_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            rv_reg  <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            rv_reg <= vld_reg[raddr];
        end
    end

    assign rdata = rv_reg ? rd_reg : '0;
endmodule

@@ tb/max_flow_bfs_augment_core_test.sv @@
// Testbench for the max-flow core: directed table, random graphs, flow predictor.
`timescale 1ns / 1ps
module max_flow_bfs_augment_core_test
    import mfbfs_pkg::*;
();

    localparam int N_MAX = MAX_NODES_DEF;
    localparam int WATCHDOG_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 2000;

    // Idle modes: none, sender idle, receiver stall, both.
    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [1:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    logic              req_type;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
    logic              out_valid;
    logic              out_stall;
    logic [FLOW_W-1:0] max_flow;

    max_flow_bfs_augment_core dut (.*);

    // Shadow of the residual matrix and node count.
    logic [CAP_W-1:0]  shadow_cap [N_MAX*N_MAX];
    logic [CFG_W-1:0]  shadow_count;
    logic [FLOW_W-1:0] flow_queue [$];

    idle_mode_t mode;
    int  mismatches;
    int  watchdog;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Count cycles with no accepted transaction on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
    end

    // Receiver: stall per mode, changed at the falling edge.
    always @(negedge clk)
    begin
        if (mode == IDLE_RECV || mode == IDLE_BOTH)
            out_stall <= ($urandom_range(99) < 65);
        else
            out_stall <= 1'b0;
    end

    // Check each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (flow_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result max_flow=%0d", max_flow);
            end
            else
            begin
                if (flow_queue[0] !== max_flow)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("max_flow mismatch: expected %0d actual %0d",
                                 flow_queue[0], max_flow);
                end
                void'(flow_queue.pop_front());
            end
        end
    end

    function automatic int effective_nodes();
        return (shadow_count > N_MAX) ? N_MAX : int'(shadow_count);
    endfunction

    // Search from node 0 in ascending order; fill parents; true on sink.
    function automatic bit find_path(input int n, ref int parent [N_MAX]);
        bit seen [N_MAX];
        int fifo [N_MAX];
        int head;
        int tail;
        int u;
        head = 0;
        tail = 0;
        foreach (seen[i]) seen[i] = 1'b0;
        fifo[tail++] = 0;
        seen[0] = 1'b1;
        parent[0] = 0;
        while (head < tail && head < N_MAX)
        begin
            u = fifo[head++];
            for (int v = 0; v < n; v++)
            begin
                if (!seen[v] && shadow_cap[u*N_MAX+v] != 0)
                begin
                    if (tail < N_MAX)
                        fifo[tail++] = v;
                    parent[v] = u;
                    seen[v] = 1'b1;
                    if (v == n-1)
                        return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // Augment along shortest paths until none is left; return total flow.
    function automatic logic [FLOW_W-1:0] augment_flow();
        int n;
        int parent [N_MAX];
        int total;
        int neck;
        int v;
        int u;
        int back;
        n = effective_nodes();
        total = 0;
        if (n < 2)
            return '0;
        while (find_path(n, parent))
        begin
            neck = int'(CAP_MAX);
            v = n-1;
            for (int s = 0; v != 0 && s < n; s++)
            begin
                u = parent[v];
                if (int'(shadow_cap[u*N_MAX+v]) < neck)
                    neck = int'(shadow_cap[u*N_MAX+v]);
                v = u;
            end
            v = n-1;
            for (int s = 0; v != 0 && s < n; s++)
            begin
                u = parent[v];
                back = int'(shadow_cap[v*N_MAX+u]) + neck;
                shadow_cap[u*N_MAX+v] = CAP_W'(int'(shadow_cap[u*N_MAX+v]) - neck);
                shadow_cap[v*N_MAX+u] = (back > int'(CAP_MAX)) ? CAP_MAX : CAP_W'(back);
                v = u;
            end
            total += neck;
            if (total > int'(FLOW_MAX))
                total = int'(FLOW_MAX);
        end
        return total[FLOW_W-1:0];
    endfunction

    // Two-phase APB write; registered on the access edge.
    task automatic write_node_count(input logic [CFG_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= ADDR_NODE_COUNT;
        pwdata  <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_count = value;
    endtask

    // Send one transaction, predicting at acceptance. A typed expectation
    // (check_flow) is cross-checked against the predictor.
    task automatic send_item(input logic rt, input logic [NODE_W-1:0] fn,
                             input logic [NODE_W-1:0] tn, input bit check_flow,
                             input logic [FLOW_W-1:0] typed_flow);
        logic [FLOW_W-1:0] predicted;
        int n;
        if (mode == IDLE_SEND || mode == IDLE_BOTH)
            while ($urandom_range(99) < 65)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        in_valid  <= 1'b1;
        req_type  <= rt;
        from_node <= fn;
        to_node   <= tn;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        n = effective_nodes();
        if (rt == REQ_ADD)
        begin
            if (fn < n && tn < n)
                shadow_cap[fn*N_MAX+tn] = 2'd1;
        end
        else
        begin
            predicted = augment_flow();
            if (check_flow && predicted !== typed_flow)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table flow %0d differs from predicted %0d",
                             typed_flow, predicted);
            end
            flow_queue.push_back(predicted);
        end
        @(negedge clk);
    endtask

    // Drop valid, wait for every result, then let the core settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (flow_queue.size() != 0 && watchdog < WATCHDOG_LIMIT)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    typedef struct {
        logic       rt;
        logic [3:0] fn;
        logic [3:0] tn;
        bit         typed;
        logic [3:0] flow;
    } table_row_t;

    table_row_t rows [14];

    // Random graph: mostly edges inside the node range, some noise.
    task automatic random_phase(input int items);
        int n;
        for (int k = 0; k < items; k++)
        begin
            n = effective_nodes();
            if ($urandom_range(99) < 12)
                send_item(REQ_RUN, 4'($urandom), 4'($urandom), 0, '0);
            else if ($urandom_range(99) < 85 && n >= 2)
                send_item(REQ_ADD, 4'($urandom_range(n-1)),
                          4'($urandom_range(n-1)), 0, '0);
            else
                send_item(REQ_ADD, 4'($urandom), 4'($urandom), 0, '0);
        end
        send_item(REQ_RUN, '0, '0, 0, '0);
    endtask

    initial
    begin
        logic [CFG_W-1:0] counts [6];
        foreach (shadow_cap[i]) shadow_cap[i] = '0;
        shadow_count = NODE_COUNT_RST;
        mismatches = 0;
        watchdog   = 0;
        mode       = IDLE_NONE;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        in_valid = 0; req_type = REQ_ADD; from_node = '0; to_node = '0;
        out_stall = 0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Watchdog: end the run if nothing moves for too long.
        fork
            begin
                wait (watchdog >= WATCHDOG_LIMIT);
                $display("status: fail");
                $finish;
            end
        join_none

        // Directed: empty graph, chain, parallel paths, self loop, range.
        rows = '{
            '{REQ_RUN, 4'd0,  4'd0,  1, 4'd0},
            '{REQ_ADD, 4'd0,  4'd15, 0, 4'd0},
            '{REQ_ADD, 4'd0,  4'd0,  0, 4'd0},
            '{REQ_ADD, 4'd15, 4'd15, 0, 4'd0},
            '{REQ_RUN, 4'd0,  4'd0,  1, 4'd1},
            '{REQ_RUN, 4'd0,  4'd0,  1, 4'd0},
            '{REQ_ADD, 4'd0,  4'd1,  0, 4'd0},
            '{REQ_ADD, 4'd1,  4'd15, 0, 4'd0},
            '{REQ_ADD, 4'd0,  4'd2,  0, 4'd0},
            '{REQ_ADD, 4'd2,  4'd3,  0, 4'd0},
            '{REQ_ADD, 4'd3,  4'd15, 0, 4'd0},
            '{REQ_RUN, 4'd15, 4'd15, 1, 4'd2},
            '{REQ_ADD, 4'd15, 4'd0,  0, 4'd0},
            '{REQ_RUN, 4'd0,  4'd0,  0, 4'd0}
        };
        foreach (rows[i])
            send_item(rows[i].rt, rows[i].fn, rows[i].tn, rows[i].typed,
                      rows[i].flow);
        drain();

        // Small and out-of-range node counts: tiny or clipped graphs.
        write_node_count(5'd1);
        send_item(REQ_ADD, 4'd0, 4'd0, 0, '0);
        send_item(REQ_RUN, 4'd0, 4'd0, 1, 4'd0);
        drain();
        write_node_count(5'd0);
        send_item(REQ_RUN, 4'd0, 4'd0, 1, 4'd0);
        drain();
        write_node_count(5'd2);
        send_item(REQ_ADD, 4'd1, 4'd1, 0, '0);
        send_item(REQ_ADD, 4'd0, 4'd1, 0, '0);
        send_item(REQ_ADD, 4'd0, 4'd9, 0, '0);
        send_item(REQ_RUN, 4'd0, 4'd0, 0, '0);
        drain();
        write_node_count(5'd31);
        send_item(REQ_RUN, 4'd0, 4'd0, 0, '0);
        drain();

        // Random phases across idle modes and node counts.
        counts = '{5'd4, 5'd16, 5'd2, 5'd8, 5'd31, 5'd6};
        for (int p = 0; p < 8; p++)
        begin
            mode = idle_mode_t'(p % 4);
            write_node_count(counts[p % 6] == 5'd31 ? 5'($urandom_range(31))
                                                     : counts[p % 6]);
            random_phase(70);
            drain();
        end

        mode = IDLE_NONE;
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && flow_queue.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
